>>> rtl/core/sleep_timer_table_top_macros.svh
// Assertion macros shared by the sleep timer table RTL.
`ifndef SLEEP_TIMER_TABLE_TOP_MACROS_SVH
`define SLEEP_TIMER_TABLE_TOP_MACROS_SVH
`ifndef SYNTH
// plain property, sampled on clk, off during reset
`define STT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// antecedent implies consequent in the same cycle
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/stt_pkg.sv
// Types and constants of the sleep timer table.
package stt_pkg;

	localparam int MS_PER_TICK = 55;
	localparam int MS_W = 32;
	localparam int PID_W = 8;
	localparam int TICK_W = 27;
	// x / 55 == (x * (2^32 + RECIP_LO)) >> RECIP_SHIFT for every 32-bit x
	localparam int RECIP_LO_W = 30;
	localparam logic [RECIP_LO_W-1:0] RECIP_LO = 30'd702812831;
	localparam int RECIP_SHIFT = 38;

	localparam logic [1:0] EV_ACCEPTED = 2'd0;
	localparam logic [1:0] EV_TOO_SHORT = 2'd1;
	localparam logic [1:0] EV_FULL = 2'd2;
	localparam logic [1:0] EV_WOKEN = 2'd3;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [PID_W-1:0] process_id;
		logic [MS_W-1:0] milliseconds;
	} req_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [PID_W-1:0] woken_id;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [TICK_W-1:0] ticks;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SLEEP_RSP,
		ST_TICK_RD,
		ST_TICK_EVAL,
		ST_TICK_END
	} state_t;

endpackage

>>> rtl/core/stt_div55.sv
// Divide by the tick length through a reciprocal multiply: a registered product, then a registered sum and shift.
module stt_div55 (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [stt_pkg::MS_W-1:0] dividend,
	output stt_pkg::div_stat_t stat,
	output logic [stt_pkg::MS_W-1:0] quotient
);
	import stt_pkg::*;

	localparam int PROD_W = MS_W + RECIP_LO_W;
	localparam int SUM_W = 2 * MS_W + 1;

	logic busy_q, done_q, phase_q;
	logic [MS_W-1:0] x_q;
	logic [PROD_W-1:0] prod_q;
	logic [TICK_W-1:0] quot_q;
	logic [SUM_W-1:0] sum;

	// x * 2^32 + x * RECIP_LO, quotient is the top TICK_W bits
	assign sum = {1'b0, x_q, {MS_W{1'b0}}} + SUM_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (busy_q && !phase_q) begin
			prod_q <= x_q * RECIP_LO;
		end
		if (busy_q && phase_q) begin
			quot_q <= sum[SUM_W-1:RECIP_SHIFT];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = MS_W'(quot_q);

endmodule

>>> rtl/core/sleep_timer_table_top.sv
// Sleep timer table: top level with sequencer, ring store and result register.
// Sleep request: divider product and sum steps, its done strobe, then the decision, held while rsp_stall.
// Tick: a read and an evaluate state per stored entry, then a closing state; an empty
//   table finishes at once. Wake results leave one per emit, held by rsp_stall.
// One transaction is in work at a time; req_stall is high until it is finished.
// Reset (arst_n, async) empties the table by clearing the fill count; no clearing pass.
`include "sleep_timer_table_top_macros.svh"

module sleep_timer_table_top #(
	parameter int MAX_SLEEPERS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input stt_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output stt_pkg::rsp_t rsp
);
	import stt_pkg::*;

	// ring pointer and fill count widths
	localparam int PW = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
	localparam int CW = $clog2(MAX_SLEEPERS + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(MAX_SLEEPERS - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_SLEEPERS);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_LAST : p - PW'(1);
	endfunction

	// The list lives in a ring: newest entry at head_q, count_q entries follow.
	// A sleep moves head back by one; a tick reads from rd_ptr and writes the
	// survivors back at wr_ptr, which never runs ahead of the read side.
	entry_t mem [MAX_SLEEPERS];
	entry_t rd_data_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, idx_q, keep_q;
	logic [PW-1:0] head_q, rd_ptr_q, wr_ptr_q;
	logic [PID_W-1:0] pid_q, pend_pid_q;
	logic pend_valid_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// sequencer strobes
	logic div_start, emit, out_free, woke;
	logic scan_init, scan_step, scan_keep, pend_load, pend_clear;
	logic sleep_commit, tick_commit;
	logic mem_we;
	logic [PW-1:0] mem_waddr;
	entry_t mem_wdata;
	rsp_t emit_item;

	div_stat_t div_stat;
	logic [MS_W-1:0] quotient;

	// divide unit: milliseconds to ticks
	stt_div55 u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(req.milliseconds),
		.stat(div_stat),
		.quotient(quotient)
	);

	// result register may be refilled in the cycle it is taken
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign woke = (rd_data_q.ticks <= TICK_W'(1));

	always_comb begin
		state_d = state_q;
		req_stall = (state_q != ST_IDLE);
		div_start = 1'b0;
		emit = 1'b0;
		emit_item = '{event_res: EV_WOKEN, woken_id: pend_pid_q, last: 1'b0};
		scan_init = 1'b0;
		scan_step = 1'b0;
		scan_keep = 1'b0;
		pend_load = 1'b0;
		pend_clear = 1'b0;
		sleep_commit = 1'b0;
		tick_commit = 1'b0;
		mem_we = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = '{pid: rd_data_q.pid, ticks: rd_data_q.ticks - TICK_W'(1)};
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.cmd == CMD_SLEEP) begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end else if (count_q != '0) begin
						scan_init = 1'b1;
						state_d = ST_TICK_RD;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_SLEEP_RSP;
				end
			end
			ST_SLEEP_RSP: begin
				emit_item.woken_id = pid_q;
				emit_item.last = 1'b1;
				if (quotient == '0) begin
					emit_item.event_res = EV_TOO_SHORT;
				end else if (count_q == CNT_FULL) begin
					emit_item.event_res = EV_FULL;
				end else begin
					emit_item.event_res = EV_ACCEPTED;
				end
				if (out_free) begin
					emit = 1'b1;
					state_d = ST_IDLE;
					if (emit_item.event_res == EV_ACCEPTED) begin
						mem_we = 1'b1;
						mem_waddr = ptr_dec(head_q);
						mem_wdata = '{pid: pid_q, ticks: quotient[TICK_W-1:0]};
						sleep_commit = 1'b1;
					end
				end
			end
			ST_TICK_RD: begin
				state_d = ST_TICK_EVAL;
			end
			ST_TICK_EVAL: begin
				if (woke) begin
					// the previous waker is not last: send it now
					if (!pend_valid_q || out_free) begin
						emit = pend_valid_q;
						pend_load = 1'b1;
						scan_step = 1'b1;
					end
				end else begin
					mem_we = 1'b1;
					scan_keep = 1'b1;
					scan_step = 1'b1;
				end
				if (scan_step) begin
					state_d = (idx_q + CW'(1) == count_q) ? ST_TICK_END : ST_TICK_RD;
				end
			end
			ST_TICK_END: begin
				emit_item.last = 1'b1;
				if (!pend_valid_q) begin
					tick_commit = 1'b1;
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					pend_clear = 1'b1;
					tick_commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			head_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			idx_q <= '0;
			keep_q <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (scan_init) begin
				rd_ptr_q <= head_q;
				wr_ptr_q <= head_q;
				idx_q <= '0;
				keep_q <= '0;
				pend_valid_q <= 1'b0;
			end
			if (scan_step) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				idx_q <= idx_q + CW'(1);
			end
			if (scan_keep) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
				keep_q <= keep_q + CW'(1);
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (sleep_commit) begin
				head_q <= ptr_dec(head_q);
				count_q <= count_q + CW'(1);
			end else if (tick_commit) begin
				count_q <= keep_q;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and ring store
	always_ff @(posedge clk) begin
		if (div_start) begin
			pid_q <= req.process_id;
		end
		if (pend_load) begin
			pend_pid_q <= rd_data_q.pid;
		end
		if (emit) begin
			rsp_q <= emit_item;
		end
		if (state_q == ST_TICK_RD) begin
			rd_data_q <= mem[rd_ptr_q];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`STT_ASSERT(a_count_bound, count_q <= CNT_FULL, "fill count above table size")
	`STT_ASSERT(a_keep_le_idx, keep_q <= idx_q, "write side ran ahead of read side")
	`STT_ASSERT_IMP(a_emit_free, emit, out_free, "result overwrote a waiting transaction")
	`STT_ASSERT_IMP(a_div_in_div, div_stat.busy || div_stat.done, state_q == ST_DIV,
		"divider active outside the divide state")

endmodule
